[src/usf_pkg.sv]
// shared types and constants of the utf-8 slot packet framer
package usf_pkg;

   localparam int SLOT_BYTES = 24;
   localparam int SLOT_AW = 5;
   localparam int MAX_SLOTS = 6;
   localparam logic [4:0] SUM_END_POS = 5'd27;
   localparam logic [4:0] SLOT_FIRST_POS = 5'd4;
   localparam logic [4:0] FRAME_LAST_POS = 5'd31;
   localparam logic [4:0] RD_FIRST_POS = 5'd3;
   localparam logic [4:0] RD_LAST_POS = 5'd26;
   localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
   localparam logic [SLOT_AW-1:0] SLOT_LAST_ADDR = 5'd23;

   typedef struct packed {
      logic                 wr;
      logic                 rd;
      logic [SLOT_AW-1:0]   addr;
      logic [7:0]           wdata;
   } ram_req_type;

   typedef struct packed {
      logic start;
      logic data_frame;
      logic nl_frame;
   } frame_req_type;

endpackage

[src/usf_slot_ram.sv]
// slot byte memory, one port, registered read
module usf_slot_ram
   import usf_pkg::*;
(
   input  logic        clock,
   input  ram_req_type req,
   output logic [7:0]  rd_data
);

   logic [7:0] mem [SLOT_BYTES];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.rd) begin
         rd_data_ff <= mem[req.addr];
      end
      if (req.wr) begin
         mem[req.addr] <= req.wdata;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/usf_pack.sv]
// character tracking and slot write address for incoming message bytes
module usf_pack
   import usf_pkg::*;
#(
   parameter int CHARS_PER_FRAME = 6
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    in_byte,
   input  logic          byte_valid,
   input  logic          end_of_message,
   output ram_req_type   wr_req,
   output frame_req_type frame_req
);

   localparam int LIMIT_INT = (CHARS_PER_FRAME > MAX_SLOTS) ? MAX_SLOTS :
                              ((CHARS_PER_FRAME < 1) ? 1 : CHARS_PER_FRAME);
   localparam logic [2:0] SLOT_LIMIT = 3'(LIMIT_INT);
   localparam logic [2:0] LAST_SLOT = 3'(MAX_SLOTS - 1);

   logic [2:0] char_count_ff, char_count_in;
   logic [2:0] bytes_left_ff, bytes_left_in;
   logic [1:0] byte_in_slot_ff, byte_in_slot_in;
   logic [2:0] slot;
   logic [1:0] offset;
   logic       full;
   logic       flush;

   function automatic logic [2:0] lead_extra(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b[7:5] == 3'b110) begin
         n = 3'd1;
      end else if (b[7:4] == 4'b1110) begin
         n = 3'd2;
      end else if (b[7:3] == 5'b11110) begin
         n = 3'd3;
      end
      return n;
   endfunction

   always_comb begin
      slot = (char_count_ff > LAST_SLOT) ? LAST_SLOT : char_count_ff;
      offset = 2'd0;
      char_count_in = char_count_ff;
      bytes_left_in = bytes_left_ff;
      byte_in_slot_in = byte_in_slot_ff;
      full = 1'b0;
      if (byte_valid) begin
         if (bytes_left_ff == 3'd0) begin
            offset = 2'd0;
            bytes_left_in = lead_extra(in_byte);
            byte_in_slot_in = 2'd1;
         end else begin
            offset = byte_in_slot_ff;
            byte_in_slot_in = byte_in_slot_ff + 2'd1;
            bytes_left_in = bytes_left_ff - 3'd1;
         end
         if (bytes_left_in == 3'd0) begin
            byte_in_slot_in = 2'd0;
            char_count_in = char_count_ff + 3'd1;
            if (char_count_in >= SLOT_LIMIT) begin
               full = 1'b1;
               char_count_in = 3'd0;
            end
         end
      end
      flush = end_of_message && (char_count_in != 3'd0 || bytes_left_in != 3'd0);
      if (end_of_message) begin
         char_count_in = 3'd0;
         bytes_left_in = 3'd0;
         byte_in_slot_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= 3'd0;
         bytes_left_ff <= 3'd0;
         byte_in_slot_ff <= 2'd0;
      end else if (accept) begin
         char_count_ff <= char_count_in;
         bytes_left_ff <= bytes_left_in;
         byte_in_slot_ff <= byte_in_slot_in;
      end
   end

   always_comb begin
      wr_req.wr = accept && byte_valid;
      wr_req.rd = 1'b0;
      wr_req.addr = {slot, offset};
      wr_req.wdata = in_byte;
      frame_req.data_frame = full || flush;
      frame_req.nl_frame = end_of_message;
      frame_req.start = accept && (full || flush || end_of_message);
   end

endmodule

[src/usf_emit.sv]
// frame sequencer: clearing sweep, byte emission, checksum, output register
module usf_emit
   import usf_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  frame_req_type frame_req,
   input  logic [30:0]   source_id,
   input  logic [7:0]    rd_data,
   output ram_req_type   ram_req,
   output logic          idle,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [15:0]   rsp_tdata,
   output logic          rsp_tlast,
   output logic          rsp_tuser
);

   localparam logic [1:0] ST_CLEAR = 2'd0;
   localparam logic [1:0] ST_IDLE = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]         state_ff, state_in;
   logic [4:0]         pos_ff, pos_in;
   logic               nl_mode_ff, nl_mode_in;
   logic               nl_pend_ff, nl_pend_in;
   logic [31:0]        sum_ff, sum_in;
   logic [SLOT_AW-1:0] clr_addr_ff, clr_addr_in;
   logic               valid_ff, valid_in;
   logic [7:0]         byte_ff, byte_in;
   logic [4:0]         opos_ff, opos_in;
   logic               last_ff, last_in;
   logic               mlast_ff, mlast_in;
   logic               load_ok;
   logic [7:0]         cur_byte;
   logic [31:0]        id_word;

   assign id_word = {1'b0, source_id};
   assign load_ok = !valid_ff || rsp_tready;

   always_comb begin
      if (pos_ff < SLOT_FIRST_POS) begin
         cur_byte = id_word[8*pos_ff[1:0] +: 8];
      end else if (pos_ff > SUM_END_POS) begin
         cur_byte = sum_ff[8*pos_ff[1:0] +: 8];
      end else if (nl_mode_ff) begin
         cur_byte = (pos_ff == SLOT_FIRST_POS) ? NEWLINE_BYTE : 8'd0;
      end else begin
         cur_byte = rd_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      nl_mode_in = nl_mode_ff;
      nl_pend_in = nl_pend_ff;
      sum_in = sum_ff;
      clr_addr_in = clr_addr_ff;
      valid_in = valid_ff && !rsp_tready;
      byte_in = byte_ff;
      opos_in = opos_ff;
      last_in = last_ff;
      mlast_in = mlast_ff;
      ram_req.wr = 1'b0;
      ram_req.rd = 1'b0;
      ram_req.addr = clr_addr_ff;
      ram_req.wdata = 8'd0;
      case (state_ff)
         ST_CLEAR: begin
            ram_req.wr = 1'b1;
            clr_addr_in = clr_addr_ff + SLOT_AW'(1);
            if (clr_addr_ff == SLOT_LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (frame_req.start) begin
               state_in = ST_EMIT;
               pos_in = 5'd0;
               sum_in = 32'd0;
               nl_mode_in = !frame_req.data_frame;
               nl_pend_in = frame_req.data_frame && frame_req.nl_frame;
            end
         end
         ST_EMIT: begin
            if (load_ok) begin
               valid_in = 1'b1;
               byte_in = cur_byte;
               opos_in = pos_ff;
               last_in = (pos_ff == FRAME_LAST_POS);
               mlast_in = (pos_ff == FRAME_LAST_POS) && nl_mode_ff;
               if (pos_ff <= SUM_END_POS) begin
                  sum_in = sum_ff + {{24{cur_byte[7]}}, cur_byte};
               end
               // fetch and clear the slot byte needed next
               if (!nl_mode_ff && pos_ff >= RD_FIRST_POS && pos_ff <= RD_LAST_POS) begin
                  ram_req.wr = 1'b1;
                  ram_req.rd = 1'b1;
                  ram_req.addr = SLOT_AW'(pos_ff - RD_FIRST_POS);
               end
               if (pos_ff == FRAME_LAST_POS) begin
                  if (nl_pend_ff) begin
                     nl_mode_in = 1'b1;
                     nl_pend_in = 1'b0;
                     pos_in = 5'd0;
                     sum_in = 32'd0;
                  end else begin
                     state_in = ST_IDLE;
                  end
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_addr_ff <= '0;
         valid_ff <= 1'b0;
         pos_ff <= 5'd0;
         nl_mode_ff <= 1'b0;
         nl_pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_addr_ff <= clr_addr_in;
         valid_ff <= valid_in;
         pos_ff <= pos_in;
         nl_mode_ff <= nl_mode_in;
         nl_pend_ff <= nl_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      byte_ff <= byte_in;
      opos_ff <= opos_in;
      last_ff <= last_in;
      mlast_ff <= mlast_in;
   end

   assign idle = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {3'd0, opos_ff, byte_ff};
   assign rsp_tlast = last_ff;
   assign rsp_tuser = mlast_ff;

endmodule

[src/utf8_slot_packet_framer.sv]
// utf-8 slot packet framer top level
// a completing item starts the emit state; it loads the first word into the output register
// throughput: one frame word per cycle when the receiver does not stall; the input is held while
// a frame is sent, through both for an item with a flush and a newline frame; others do not hold it
// reset: synchronous; a sweep then zeroes the slot memory, no item is taken meanwhile
// configuration writes are taken at all times; source_id resets to zero
module utf8_slot_packet_framer
   import usf_pkg::*;
#(
   parameter int CHARS_PER_FRAME = 6
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // in_byte
   input  logic        req_tuser,   // byte_valid
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // frame_byte [7:0], byte_position [12:8], zero fill
   output logic        rsp_tlast,   // frame_last
   output logic        rsp_tuser,   // message_last
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic          accept;
   logic          idle;
   logic [30:0]   source_id_ff;
   logic [7:0]    rd_data;
   ram_req_type   wr_req;
   ram_req_type   emit_req;
   ram_req_type   ram_req;
   frame_req_type frame_req;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == 1'b0) ? {1'b0, source_id_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         source_id_ff <= 31'd0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_paddr[2] == 1'b0) begin
         source_id_ff <= csr_pwdata[30:0];
      end
   end

   assign req_tready = idle;
   assign accept = req_tvalid && idle;
   assign ram_req = wr_req.wr ? wr_req : emit_req;

   usf_pack #(
      .CHARS_PER_FRAME(CHARS_PER_FRAME)
   ) u_pack (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .in_byte        (req_tdata),
      .byte_valid     (req_tuser),
      .end_of_message (req_tlast),
      .wr_req         (wr_req),
      .frame_req      (frame_req)
   );

   usf_slot_ram u_ram (
      .clock   (clock),
      .req     (ram_req),
      .rd_data (rd_data)
   );

   usf_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .frame_req  (frame_req),
      .source_id  (source_id_ff),
      .rd_data    (rd_data),
      .ram_req    (emit_req),
      .idle       (idle),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[src/usf_checker.sv]
// port checks of the framer and their binding to the top level
module usf_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);

   // no word right after reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("word shown right after reset");

   // message end only on a frame's last word
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("message end off frame end");

   // frame end flag matches the last position
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tlast == (rsp_tdata[12:8] == 5'd31)))
      else $error("frame end flag and position disagree");

   // positions inside a frame count up by one
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast ##1 rsp_tvalid
      |-> rsp_tdata[12:8] == $past(rsp_tdata[12:8]) + 5'd1)
      else $error("position skipped");

   // a new frame starts at position zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast ##1 rsp_tvalid |-> rsp_tdata[12:8] == 5'd0)
      else $error("frame does not start at zero");

endmodule

bind utf8_slot_packet_framer usf_checker u_usf_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

[dv/utf8_slot_packet_framer_checker.sv]
// frame prediction and word checking for the utf-8 slot packet framer
`timescale 1ns / 1ps

package usf_test_pkg;

   localparam logic [2:0] SOURCE_ID_ADDR = 3'd0;
   localparam logic [2:0] SPARE_ADDR = 3'd4;

endpackage

module usf_frame_monitor
   import usf_pkg::*;
   import usf_test_pkg::*;
#(
   parameter int CHARS_PER_FRAME = 6
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tuser,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [15:0] rsp_tdata,
   input  logic        rsp_tlast,
   input  logic        rsp_tuser,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   input  logic [31:0] csr_prdata,
   input  logic        csr_pready,
   output int          fail_count,
   output int          words_pending
);

   localparam int FRAME_CHARS = (CHARS_PER_FRAME > MAX_SLOTS) ? MAX_SLOTS :
                                (CHARS_PER_FRAME < 1) ? 1 : CHARS_PER_FRAME;

   typedef struct {
      logic [7:0] value;
      logic [4:0] pos;
      logic       frame_end;
      logic       message_end;
   } frame_word_type;

   frame_word_type expected_words[$];

   logic [30:0] sender_id;
   logic [7:0]  slot_bytes [SLOT_BYTES];
   int unsigned chars_done;
   int unsigned cont_left;
   int unsigned slot_pos;

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fail_count++;
   endtask

   function automatic int unsigned char_length(input logic [7:0] lead);
      casez (lead)
         8'b0???????: return 1;
         8'b110?????: return 2;
         8'b1110????: return 3;
         8'b11110???: return 4;
         default: return 1;
      endcase
   endfunction

   task automatic clear_slots();
      foreach (slot_bytes[i]) slot_bytes[i] = 8'h00;
      chars_done = 0;
      cont_left = 0;
      slot_pos = 0;
   endtask

   task automatic queue_frame(input bit newline_frame);
      logic [7:0]  frame [32];
      logic [31:0] sum;
      logic [31:0] id;
      frame_word_type w;
      id = {1'b0, sender_id};
      for (int i = 0; i < 4; i++) frame[i] = id[8*i +: 8];
      for (int i = 0; i < SLOT_BYTES; i++) frame[4 + i] = slot_bytes[i];
      sum = '0;
      for (int i = 0; i < 28; i++) sum = sum + {{24{frame[i][7]}}, frame[i]};
      for (int i = 0; i < 4; i++) frame[28 + i] = sum[8*i +: 8];
      for (int i = 0; i < 32; i++) begin
         w.value = frame[i];
         w.pos = 5'(i);
         w.frame_end = (i == 31);
         w.message_end = (i == 31) && newline_frame;
         expected_words.push_back(w);
      end
      clear_slots();
   endtask

   task automatic take_message_byte(input logic [7:0] b, output bit frame_full);
      int unsigned slot;
      slot = (chars_done >= MAX_SLOTS) ? MAX_SLOTS - 1 : chars_done;
      frame_full = 1'b0;
      if (cont_left == 0) begin
         slot_bytes[slot * 4] = b;
         cont_left = char_length(b) - 1;
         slot_pos = 1;
      end else begin
         slot_bytes[slot * 4 + (slot_pos & 3)] = b;
         slot_pos = (slot_pos + 1) & 3;
         cont_left--;
      end
      if (cont_left == 0) begin
         slot_pos = 0;
         chars_done++;
         frame_full = (chars_done >= FRAME_CHARS);
      end
   endtask

   task automatic predict_item(input logic [7:0] b, input logic present, input logic eom);
      bit full;
      if (present) begin
         take_message_byte(b, full);
         if (full) queue_frame(1'b0);
      end
      if (eom) begin
         if (chars_done != 0 || cont_left != 0) queue_frame(1'b0);
         clear_slots();
         slot_bytes[0] = NEWLINE_BYTE;
         queue_frame(1'b1);
      end
   endtask

   task automatic check_word();
      frame_word_type want;
      if (expected_words.size() == 0) begin
         report_mismatch("unexpected word", 32'h0, {16'h0, rsp_tdata});
      end else begin
         want = expected_words.pop_front();
         if (rsp_tdata[7:0] !== want.value)
            report_mismatch("frame byte", 32'(want.value), 32'(rsp_tdata[7:0]));
         if (rsp_tdata[12:8] !== want.pos)
            report_mismatch("byte position", 32'(want.pos), 32'(rsp_tdata[12:8]));
         if (rsp_tdata[15:13] !== 3'b000)
            report_mismatch("zero fill", 32'h0, 32'(rsp_tdata[15:13]));
         if (rsp_tlast !== want.frame_end)
            report_mismatch("frame last", 32'(want.frame_end), 32'(rsp_tlast));
         if (rsp_tuser !== want.message_end)
            report_mismatch("message last", 32'(want.message_end), 32'(rsp_tuser));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         sender_id = '0;
         clear_slots();
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_word();
         if (csr_psel && csr_penable && csr_pready) begin
            if (csr_pwrite) begin
               if (csr_paddr == SOURCE_ID_ADDR) sender_id = csr_pwdata[30:0];
            end else if (csr_paddr == SOURCE_ID_ADDR && csr_prdata !== {1'b0, sender_id}) begin
               report_mismatch("source id read", {1'b0, sender_id}, csr_prdata);
            end
         end
         if (req_tvalid && req_tready) predict_item(req_tdata, req_tuser, req_tlast);
      end
      words_pending <= expected_words.size();
   end

endmodule

[dv/utf8_slot_packet_framer_test.sv]
// stimulus and verdict for the utf-8 slot packet framer
`timescale 1ns / 1ps

module utf8_slot_packet_framer_test;
   import usf_test_pkg::*;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        rsp_tlast;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;
   int          fail_count;
   int          words_pending;

   logic [7:0]  message_text[$];
   int          burst_left = 0;
   int          items_sent;
   int          ready_run = 0;
   int          ready_mode = 0;

   utf8_slot_packet_framer DUT (.*);

   usf_frame_monitor frame_monitor (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // receiver stall pattern
   always @(negedge clock) begin
      if (ready_run == 0) begin
         ready_mode = $urandom_range(0, 3);
         ready_run = (ready_mode == 3) ? $urandom_range(2, 16) : $urandom_range(4, 40);
      end
      ready_run--;
      case (ready_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ($urandom_range(0, 3) != 0);
         default: rsp_tready <= (ready_run < 2);
      endcase
   end

   task automatic send_word(input logic [7:0] b, input logic present, input logic eom);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tuser <= present;
      req_tlast <= eom;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_source_id(input logic [31:0] value);
      csr_access(1'b1, SOURCE_ID_ADDR, value);
      csr_access(1'b0, SOURCE_ID_ADDR, 32'h0);
   endtask

   task automatic send_message_text(input bit eom_on_last);
      int n;
      n = message_text.size();
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 19) == 0) send_word(8'($urandom), 1'b0, 1'b0);
         send_word(message_text[i], 1'b1, eom_on_last && (i == n - 1));
         items_sent++;
      end
      if (!eom_on_last || n == 0) begin
         send_word(8'($urandom), 1'b0, 1'b1);
         items_sent++;
      end
   endtask

   function automatic logic [7:0] cont_byte();
      if ($urandom_range(0, 7) == 0) return 8'($urandom);
      return 8'h80 | 8'($urandom_range(0, 63));
   endfunction

   task automatic build_message();
      int n_chars;
      int n_cont;
      logic [7:0] lead;
      message_text.delete();
      n_chars = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 14);
      repeat (n_chars) begin
         n_cont = 0;
         case ($urandom_range(0, 9))
            4: begin
               lead = 8'hC0 | 8'($urandom_range(0, 31));
               n_cont = 1;
            end
            5: begin
               lead = 8'hE0 | 8'($urandom_range(0, 15));
               n_cont = 2;
            end
            6: begin
               lead = 8'hF0 | 8'($urandom_range(0, 7));
               n_cont = 3;
            end
            7: begin
               lead = ($urandom_range(0, 1) == 0) ? 8'h80 | 8'($urandom_range(0, 63))
                                                  : 8'hF8 | 8'($urandom_range(0, 7));
            end
            8: begin
               // broken sequence, cut short
               lead = ($urandom_range(0, 1) == 0) ? 8'hE0 | 8'($urandom_range(0, 15))
                                                  : 8'hF0 | 8'($urandom_range(0, 7));
               n_cont = $urandom_range(0, 1);
            end
            default: lead = 8'($urandom_range(0, 127));
         endcase
         message_text.push_back(lead);
         repeat (n_cont) message_text.push_back(cont_byte());
      end
      if (message_text.size() > 1 && $urandom_range(0, 7) == 0) void'(message_text.pop_back());
   endtask

   initial begin
      int msg_count;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty message with the reset source id
      csr_access(1'b0, SOURCE_ID_ADDR, 32'h0);
      message_text.delete();
      send_message_text(1'b0);
      wait_idle();
      set_source_id(32'hFFFF_FFFF);
      csr_access(1'b1, SPARE_ADDR, 32'h0000_1234);
      csr_access(1'b0, SOURCE_ID_ADDR, 32'h0);

      // every lead kind and invalid leads, then a flush with newline on one word
      message_text = '{8'h00, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98,
                       8'h80, 8'h80, 8'hFF, 8'h41};
      send_message_text(1'b1);
      wait_idle();
      set_source_id(32'h0);

      // message ends inside a character
      message_text = '{8'hE2, 8'h82};
      send_message_text(1'b0);
      wait_idle();
      set_source_id(32'h5A5A_A5A5);

      // odd continuation values, an ignored word, end on a frame boundary
      send_word(8'hFF, 1'b0, 1'b0);
      message_text = '{8'hF0, 8'h41, 8'hFF, 8'h00, 8'h7F, 8'h7F, 8'h7F, 8'h7F, 8'h7F};
      send_message_text(1'b0);

      items_sent = 0;
      msg_count = 0;
      while (items_sent < 150) begin
         if (msg_count % 3 == 0) begin
            wait_idle();
            case ($urandom_range(0, 4))
               0: set_source_id(32'h0);
               1: set_source_id(32'h7FFF_FFFF);
               2: set_source_id(32'hFFFF_FFFF);
               3: begin
                  csr_access(1'b1, SPARE_ADDR, $urandom);
                  set_source_id($urandom);
               end
               default: set_source_id($urandom);
            endcase
         end
         build_message();
         send_message_text(message_text.size() > 0 && $urandom_range(0, 2) == 0);
         msg_count++;
      end

      wait_idle();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
